// ===== design/cubic_bezier_step_vectors_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - assertion macros
// Property checks for simulation; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_STEP_VECTORS_UNIT_DEFINES_SVH
`define CUBIC_BEZIER_STEP_VECTORS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CBSV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cbsv: property check failed");
`define CBSV_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("cbsv: forbidden condition seen");
`else
`define CBSV_ASSERT(lbl, clk, rst, prop)
`define CBSV_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== design/cbsv_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - shared package
// Default parameters, fixed port widths and payload types.
// ----------------------------------------------------------------------------
package cbsv_pkg;

   localparam int SEGMENTS_DEF    = 25;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int FIELD_W         = 16;
   localparam int OUT_W           = 17;
   localparam int QUEUE_DEPTH     = 2;

   typedef logic signed [FIELD_W-1:0] coord_type;
   typedef logic signed [OUT_W-1:0]   step_type;

endpackage

// ===== design/cbsv_req_if.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - curve channel
// Valid/ready channel carrying one curve word.
// ----------------------------------------------------------------------------
interface cbsv_req_if;

   logic                valid;
   logic                ready;
   logic                is_line;
   cbsv_pkg::coord_type start_x;
   cbsv_pkg::coord_type start_y;
   cbsv_pkg::coord_type ctrl1_x;
   cbsv_pkg::coord_type ctrl1_y;
   cbsv_pkg::coord_type ctrl2_x;
   cbsv_pkg::coord_type ctrl2_y;
   cbsv_pkg::coord_type end_x;
   cbsv_pkg::coord_type end_y;

   modport source (
      output valid, is_line, start_x, start_y, ctrl1_x, ctrl1_y,
             ctrl2_x, ctrl2_y, end_x, end_y,
      input  ready
   );

   modport sink (
      input  valid, is_line, start_x, start_y, ctrl1_x, ctrl1_y,
             ctrl2_x, ctrl2_y, end_x, end_y,
      output ready
   );

endinterface

// ===== design/cbsv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - step channel
// Valid/ready channel carrying one move-vector word.
// ----------------------------------------------------------------------------
interface cbsv_rsp_if;

   logic               valid;
   logic               ready;
   cbsv_pkg::step_type step_dx;
   cbsv_pkg::step_type step_dy;
   logic               last_step;

   modport source (
      output valid, step_dx, step_dy, last_step,
      input  ready
   );

   modport sink (
      input  valid, step_dx, step_dy, last_step,
      output ready
   );

endinterface

// ===== design/cubic_bezier_step_vectors_unit.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - top level
// Turns one curve word into relative move vectors.
// ----------------------------------------------------------------------------
// req_bus takes one curve word: four control points and a line flag. rsp_bus
// gives move-vector words (step_dx, step_dy, last_step). A line gives one
// word, end minus start; a cubic gives SEGMENTS words, the differences of the
// curve sampled at t = i/SEGMENTS and rounded half up, last_step on the final.
// Path: when nothing stalls, a curve word reaches rsp_bus through two
// front-end stages, the queue, the engine load, the numerator register,
// the reciprocal multiply that divides by 2*SEGMENTS^3 and the differencing
// output register.
// Throughput: the sample engine makes one numerator a cycle by forward
// differencing while rsp_bus does not stall, so a cubic occupies it for
// SEGMENTS numerators (25 at defaults) and a line for one. The front end
// and a two-word queue take further curve words while the engine works. A
// stalled rsp_bus freezes the engine and its pipeline; the front end accepts
// until its stages and the queue fill. Reset empties all stages and the queue.
// ----------------------------------------------------------------------------
module cubic_bezier_step_vectors_unit #(
   parameter int SEGMENTS    = cbsv_pkg::SEGMENTS_DEF,
   parameter int COORD_WIDTH = cbsv_pkg::COORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cbsv_req_if.sink    req_bus,
   cbsv_rsp_if.source  rsp_bus
);

   localparam int XW = $clog2(2 * SEGMENTS**3) + COORD_WIDTH + 1;
   localparam int EW = 6 * XW + 1;

   logic          push_valid;
   logic          push_ready;
   logic [EW-1:0] push_data;
   logic          pop_valid;
   logic          pop_ready;
   logic [EW-1:0] pop_data;

   cbsv_front #(
      .SEGMENTS    (SEGMENTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cbsv_queue #(
      .WIDTH (EW),
      .DEPTH (cbsv_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cbsv_back #(
      .SEGMENTS    (SEGMENTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== design/cbsv_front.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - front end
// Accepts curve words, forms power-basis coefficients and the initial
// forward differences (scaled numerator units) pushed to the work queue.
// ----------------------------------------------------------------------------
module cbsv_front #(
   parameter int SEGMENTS    = cbsv_pkg::SEGMENTS_DEF,
   parameter int COORD_WIDTH = cbsv_pkg::COORD_WIDTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   cbsv_req_if.sink                                          req_bus,
   output logic                                              push_valid,
   input  logic                                              push_ready,
   output logic [6*($clog2(2*SEGMENTS**3)+COORD_WIDTH+1):0]  push_data
);

   localparam int CW  = COORD_WIDTH;
   localparam int QW  = CW + 1;
   localparam int KW  = CW + 5;
   localparam int MOD = 2 * SEGMENTS**3;
   localparam int XW  = $clog2(MOD) + CW + 1;
   localparam int EW  = 6 * XW + 1;
   localparam logic [XW-1:0] S_X  = XW'(SEGMENTS);
   localparam logic [XW-1:0] SS_X = XW'(SEGMENTS * SEGMENTS);
   localparam logic [XW-1:0] M_X  = XW'(MOD);

   logic signed [CW-1:0] p [8];
   logic signed [QW-1:0] q1 [2];
   logic signed [QW-1:0] q2 [2];
   logic signed [QW-1:0] q3 [2];
   logic signed [KW-1:0] ka_in [2];
   logic signed [KW-1:0] kb_in [2];
   logic signed [KW-1:0] kc_in [2];

   logic                 s1_v_ff;
   logic                 line1_ff;
   logic signed [KW-1:0] ka_ff [2];
   logic signed [KW-1:0] kb_ff [2];
   logic signed [KW-1:0] kc_ff [2];
   logic signed [QW-1:0] lq_ff [2];

   logic                 s2_v_ff;
   logic                 line2_ff;
   logic [XW-1:0]        ta_ff [2];
   logic [XW-1:0]        tb_ff [2];
   logic [XW-1:0]        tc_ff [2];
   logic [XW-1:0]        tq_ff [2];

   logic                 s1_rdy;
   logic                 s2_rdy;

   assign p[0] = CW'(req_bus.start_x);
   assign p[1] = CW'(req_bus.start_y);
   assign p[2] = CW'(req_bus.ctrl1_x);
   assign p[3] = CW'(req_bus.ctrl1_y);
   assign p[4] = CW'(req_bus.ctrl2_x);
   assign p[5] = CW'(req_bus.ctrl2_y);
   assign p[6] = CW'(req_bus.end_x);
   assign p[7] = CW'(req_bus.end_y);

   // q relative to start point; a = q3-3q2+3q1, b = 3q2-6q1, c = 3q1
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         q1[ax] = QW'(p[2+ax]) - QW'(p[ax]);
         q2[ax] = QW'(p[4+ax]) - QW'(p[ax]);
         q3[ax] = QW'(p[6+ax]) - QW'(p[ax]);
         ka_in[ax] = KW'(q3[ax]) - (KW'(q2[ax]) <<< 1) - KW'(q2[ax])
                   + (KW'(q1[ax]) <<< 1) + KW'(q1[ax]);
         kb_in[ax] = (KW'(q2[ax]) <<< 1) + KW'(q2[ax])
                   - (KW'(q1[ax]) <<< 2) - (KW'(q1[ax]) <<< 1);
         kc_in[ax] = (KW'(q1[ax]) <<< 1) + KW'(q1[ax]);
      end
   end

   assign s2_rdy        = !s2_v_ff || push_ready;
   assign s1_rdy        = !s1_v_ff || s2_rdy;
   assign req_bus.ready = s1_rdy;
   assign push_valid    = s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_v_ff <= req_bus.valid;
         end
         if (s2_rdy) begin
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && req_bus.valid) begin
         line1_ff <= req_bus.is_line;
         for (int ax = 0; ax < 2; ax++) begin
            ka_ff[ax] <= ka_in[ax];
            kb_ff[ax] <= kb_in[ax];
            kc_ff[ax] <= kc_in[ax];
            lq_ff[ax] <= q3[ax];
         end
      end
      // constant multiplies, modulo 2^XW
      if (s2_rdy && s1_v_ff) begin
         line2_ff <= line1_ff;
         for (int ax = 0; ax < 2; ax++) begin
            ta_ff[ax] <= XW'(ka_ff[ax]);
            tb_ff[ax] <= XW'(kb_ff[ax]) * S_X;
            tc_ff[ax] <= XW'(kc_ff[ax]) * SS_X;
            tq_ff[ax] <= XW'(lq_ff[ax]) * M_X;
         end
      end
   end

   // D1 = 2(a+Sb+S^2c), D2 = 12a+4Sb, D3 = 12a; a line jumps straight by M*q3
   always_comb begin
      push_data = '0;
      push_data[EW-1] = line2_ff;
      for (int ax = 0; ax < 2; ax++) begin
         push_data[ax*3*XW +: XW] = line2_ff ? tq_ff[ax]
                                   : ((ta_ff[ax] + tb_ff[ax] + tc_ff[ax]) << 1);
         push_data[ax*3*XW+XW +: XW] = (ta_ff[ax] << 3) + (ta_ff[ax] << 2)
                                      + (tb_ff[ax] << 2);
         push_data[ax*3*XW+2*XW +: XW] = (ta_ff[ax] << 3) + (ta_ff[ax] << 2);
      end
   end

endmodule

// ===== design/cbsv_queue.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - work queue
// Small FIFO between the front end and the sample engine.
// ----------------------------------------------------------------------------
`include "cubic_bezier_step_vectors_unit_defines.svh"

module cbsv_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cbsv_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff;
   logic [AW-1:0]    rd_ff;
   logic [CNW-1:0]   cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = cnt_ff != CNW'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   `CBSV_NEVER(a_empty_ptrs, clock, reset, cnt_ff == '0 && wr_ff != rd_ff)
   `CBSV_NEVER(a_full_ptrs, clock, reset, cnt_ff == CNW'(DEPTH) && wr_ff != rd_ff)

endmodule

// ===== design/cbsv_back.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier step vectors - sample engine
// Forward-difference generator of biased numerators, a reciprocal multiply
// for the division by 2*S^3, and the differencing output register.
// ----------------------------------------------------------------------------
`include "cubic_bezier_step_vectors_unit_defines.svh"

module cbsv_back #(
   parameter int SEGMENTS    = cbsv_pkg::SEGMENTS_DEF,
   parameter int COORD_WIDTH = cbsv_pkg::COORD_WIDTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              pop_valid,
   output logic                                              pop_ready,
   input  logic [6*($clog2(2*SEGMENTS**3)+COORD_WIDTH+1):0]  pop_data,
   cbsv_rsp_if.source                                        rsp_bus
);

   localparam int CW  = COORD_WIDTH;
   localparam int S3  = SEGMENTS**3;
   localparam int MOD = 2 * S3;
   localparam int XW  = $clog2(MOD) + CW + 1;
   localparam int EW  = 6 * XW + 1;
   localparam int QB  = CW + 1;
   localparam int DW  = QB + 1;
   localparam int LW  = $clog2(SEGMENTS + 1);
   localparam int OW  = cbsv_pkg::OUT_W;
   // floor(n / 2S^3) = floor(floor(n / 2) * R / 2^SH), R = ceil(2^SH / S^3)
   localparam int NW  = XW - 1;
   localparam int SH  = NW + $clog2(S3);
   localparam int PW  = NW + XW;
   localparam logic [63:0]   R_W   = ((64'd1 << SH) + 64'(S3) - 64'd1) / 64'(S3);
   localparam logic [XW-1:0] RECIP = R_W[XW-1:0];
   // numerator at t = 0 plus a bias of 2^CW quotient units
   localparam logic [XW-1:0] X0   = XW'(SEGMENTS**3) + (XW'(MOD) << CW);
   localparam logic [QB-1:0] BIAS = QB'(1) << CW;

   logic          en;
   logic          busy_ff;
   logic [LW-1:0] left_ff;
   logic          at_last;
   logic          take;
   logic          load;
   logic          emit;
   logic          e_line;
   logic [XW-1:0] e1 [2];
   logic [XW-1:0] e2 [2];
   logic [XW-1:0] e3 [2];

   logic [XW-1:0] gx_ff [2];
   logic [XW-1:0] g1_ff [2];
   logic [XW-1:0] g2_ff [2];
   logic [XW-1:0] g3_ff [2];

   logic          v0_ff;
   logic          v1_ff;
   logic          lst0_ff;
   logic          lst1_ff;
   logic [XW-1:0] num_ff  [2];
   logic [PW-1:0] prod_ff [2];
   logic [QB-1:0] quo_c   [2];

   logic [QB-1:0]        prev_ff [2];
   logic                 rsp_valid_ff;
   logic signed [OW-1:0] dx_ff;
   logic signed [OW-1:0] dy_ff;
   logic                 last_ff;
   logic signed [DW-1:0] dx_c;
   logic signed [DW-1:0] dy_c;

   assign en        = !rsp_valid_ff || rsp_bus.ready;
   assign at_last   = left_ff == '0;
   assign take      = en && (!busy_ff || at_last);
   assign pop_ready = take;
   assign load      = take && pop_valid;
   assign emit      = en && busy_ff;

   assign e_line = pop_data[EW-1];
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         e1[ax] = pop_data[ax*3*XW +: XW];
         e2[ax] = pop_data[ax*3*XW+XW +: XW];
         e3[ax] = pop_data[ax*3*XW+2*XW +: XW];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         left_ff <= e_line ? '0 : LW'(SEGMENTS - 1);
      end else if (emit) begin
         if (at_last) begin
            busy_ff <= 1'b0;
         end else begin
            left_ff <= left_ff - 1'b1;
         end
      end
   end

   // forward differences, modulo 2^XW
   always_ff @(posedge clock) begin
      for (int ax = 0; ax < 2; ax++) begin
         if (load) begin
            gx_ff[ax] <= X0;
            g1_ff[ax] <= e1[ax];
            g2_ff[ax] <= e2[ax];
            g3_ff[ax] <= e3[ax];
         end else if (emit) begin
            gx_ff[ax] <= gx_ff[ax] + g1_ff[ax];
            g1_ff[ax] <= g1_ff[ax] + g2_ff[ax];
            g2_ff[ax] <= g2_ff[ax] + g3_ff[ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= emit;
         v1_ff <= v0_ff;
      end
   end

   // biased numerator, then multiply by the reciprocal of 2*S^3
   always_ff @(posedge clock) begin
      if (en) begin
         lst0_ff <= at_last;
         lst1_ff <= lst0_ff;
         for (int ax = 0; ax < 2; ax++) begin
            num_ff[ax]  <= gx_ff[ax] + g1_ff[ax];
            prod_ff[ax] <= PW'(num_ff[ax][XW-1:1]) * PW'(RECIP);
         end
      end
   end

   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         quo_c[ax] = prod_ff[ax][SH +: QB];
      end
   end

   assign dx_c = signed'({1'b0, quo_c[0]}) - signed'({1'b0, prev_ff[0]});
   assign dy_c = signed'({1'b0, quo_c[1]}) - signed'({1'b0, prev_ff[1]});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff[0]   <= BIAS;
         prev_ff[1]   <= BIAS;
      end else if (en) begin
         rsp_valid_ff <= v1_ff;
         if (v1_ff) begin
            prev_ff[0] <= lst1_ff ? BIAS : quo_c[0];
            prev_ff[1] <= lst1_ff ? BIAS : quo_c[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && v1_ff) begin
         dx_ff   <= OW'(dx_c);
         dy_ff   <= OW'(dy_c);
         last_ff <= lst1_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.step_dx   = dx_ff;
   assign rsp_bus.step_dy   = dy_ff;
   assign rsp_bus.last_step = last_ff;

   `CBSV_NEVER(a_idle_count, clock, reset, !busy_ff && left_ff != '0)
   `CBSV_ASSERT(a_stall_hold, clock, reset, !en |=> $stable(v1_ff) && $stable(prod_ff[0]))
   `CBSV_ASSERT(a_last_mark, clock, reset, emit && at_last |=> v0_ff && lst0_ff)

endmodule
